// ===== design/websocket_frame_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder_assert.svh
// Concurrent assertion helpers for the frame encoder, clocked on clk and
// disabled while rst_n is low. Empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_ENCODER_ASSERT_SVH
`define WEBSOCKET_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// consequent checked in the same cycle
`define WFE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequent checked in the cycle after
`define WFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WFE_ASSERT_SAME(label, ante, cons, msg)
`define WFE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/wfe_pkg.sv =====
// ----------------------------------------------------------------------------
// wfe_pkg
// Types, constants and byte helpers shared by the frame encoder files.
// ----------------------------------------------------------------------------
package wfe_pkg;

  localparam int LEN_W     = 63;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = 4;   // up to 14 result bytes per request

  localparam logic       OP_FRAME_START  = 1'b0;
  localparam logic       OP_PAYLOAD_BYTE = 1'b1;

  localparam logic [6:0] LEN16_CODE  = 7'd126;
  localparam logic [6:0] LEN64_CODE  = 7'd127;
  localparam logic [LEN_W-1:0] SHORT_LIMIT = 63'd126;
  localparam logic [LEN_W-1:0] LEN16_MAX   = 63'd65535;
  localparam logic [IDX_W-1:0] KEY_BYTES   = 4'd4;
  localparam logic [IDX_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [IDX_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [IDX_W-1:0] FIXED_HDR   = 4'd2;

  typedef struct packed {
    logic             operation;
    logic             fin_flag;
    logic [3:0]       frame_opcode;
    logic [LEN_W-1:0] payload_length;
    logic             use_mask;
    logic [KEY_W-1:0] mask_key;
    logic [7:0]       payload_byte;
  } wfe_in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       frame_done;
    logic       error_flag;
  } wfe_out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] bytes_left;
    logic [1:0]       key_phase;
    logic [KEY_W-1:0] held_key;
    logic             masking_on;
  } wfe_state_t;

  function automatic logic [7:0] word64_byte(input logic [63:0] w, input logic [2:0] sel);
    word64_byte = w[{sel, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] k, input logic [1:0] sel);
    key_byte = k[{sel, 3'b000} +: 8];
  endfunction

endpackage

// ===== design/wfe_in_if.sv =====
// ----------------------------------------------------------------------------
// wfe_in_if
// Valid/ready channel carrying one encoder request.
// ----------------------------------------------------------------------------
interface wfe_in_if;
  import wfe_pkg::*;

  logic         valid;
  logic         ready;
  wfe_in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/wfe_out_if.sv =====
// ----------------------------------------------------------------------------
// wfe_out_if
// Valid/ready channel carrying one serialized frame byte.
// ----------------------------------------------------------------------------
interface wfe_out_if;
  import wfe_pkg::*;

  logic          valid;
  logic          ready;
  wfe_out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/websocket_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// WebSocket frame serializer: frame-start requests become header bytes
// (with extended length and mask key), payload requests become one
// optionally masked byte each.
//
//   channel   dir  payload          per request
//   in_chan   in   wfe_in_item_t    frame start or payload byte
//   out_chan  out  wfe_out_item_t   1 byte, 2..14 for a frame start
//
// A payload request gives one byte; a frame start gives one header byte per
// cycle while the output is not stalled (2 to 14), paced by the byte index
// counter on the request register. The next request is taken in the cycle
// its predecessor's final byte moves into the result register. Synchronous
// active-low reset clears the frame state and empties both registers.
// A stalled output holds the result register and the request register in place.
// ----------------------------------------------------------------------------
`include "websocket_frame_encoder_assert.svh"

module websocket_frame_encoder (
  input  logic     clk,
  input  logic     rst_n,
  wfe_in_if.sink   in_chan,
  wfe_out_if.source out_chan
);
  import wfe_pkg::*;

  wfe_in_item_t     item_r;
  logic             item_valid_r;
  logic             item_valid_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  wfe_state_t       state_r;
  wfe_state_t       state_nxt;

  wfe_out_item_t    gen_result;
  wfe_state_t       gen_state;
  logic             run_last;
  logic             can_load;
  logic             adv;
  logic             in_take;

  wfe_byte_gen u_byte_gen (
    .item      (item_r),
    .idx       (idx_r),
    .state     (state_r),
    .result    (gen_result),
    .run_last  (run_last),
    .state_nxt (gen_state)
  );

  wfe_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (item_valid_r),
    .load_data  (gen_result),
    .can_load   (can_load),
    .out_chan   (out_chan)
  );

  assign adv           = item_valid_r && can_load;
  assign in_chan.ready = !item_valid_r || (adv && run_last);
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    idx_nxt        = idx_r;
    state_nxt      = state_r;
    if (adv) begin
      idx_nxt = run_last ? '0 : idx_r + 4'd1;
      if (run_last) begin
        item_valid_nxt = 1'b0;
        state_nxt      = gen_state;
      end
    end
    if (in_take) begin
      item_valid_nxt = 1'b1;
      idx_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      idx_r        <= '0;
      state_r      <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      idx_r        <= idx_nxt;
      state_r      <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_chan.data;
    end
  end

  `WFE_ASSERT_NEXT(a_run_holds, adv && !run_last, item_valid_r, "request dropped mid-header")
  `WFE_ASSERT_NEXT(a_done_closes, adv && gen_result.frame_done, state_r.bytes_left == '0, "frame done but bytes left")
  `WFE_ASSERT_NEXT(a_err_keeps_state, adv && gen_result.error_flag, $stable(state_r), "stray byte changed frame state")

endmodule

// ===== design/wfe_byte_gen.sv =====
// ----------------------------------------------------------------------------
// wfe_byte_gen
// Picks the byte at position idx of the held request: header bytes for a
// frame start, one optionally masked byte for a payload request. Also gives
// the frame state that holds once the request is finished.
// ----------------------------------------------------------------------------
module wfe_byte_gen (
  input  wfe_pkg::wfe_in_item_t          item,
  input  logic [wfe_pkg::IDX_W-1:0]      idx,
  input  wfe_pkg::wfe_state_t            state,
  output wfe_pkg::wfe_out_item_t         result,
  output logic                           run_last,
  output wfe_pkg::wfe_state_t            state_nxt
);
  import wfe_pkg::*;

  logic             is_short;
  logic             is_len16;
  logic [IDX_W-1:0] ext_cnt;
  logic [IDX_W-1:0] key_cnt;
  logic [IDX_W-1:0] hdr_last_idx;
  logic [IDX_W-1:0] ext_sel;
  logic [IDX_W-1:0] key_sel;
  logic [7:0]       hdr_byte;
  logic             hdr_last;
  logic             no_frame;
  logic [7:0]       mask_byte;
  logic [LEN_W-1:0] left_dec;

  assign is_short     = item.payload_length < SHORT_LIMIT;
  assign is_len16     = !is_short && (item.payload_length <= LEN16_MAX);
  assign ext_cnt      = is_short ? '0 : (is_len16 ? EXT16_BYTES : EXT64_BYTES);
  assign key_cnt      = item.use_mask ? KEY_BYTES : '0;
  assign hdr_last_idx = FIXED_HDR - 4'd1 + ext_cnt + key_cnt;
  assign hdr_last     = (idx == hdr_last_idx);
  assign ext_sel      = idx - FIXED_HDR;
  assign key_sel      = idx - FIXED_HDR - ext_cnt;

  always_comb begin
    if (idx == '0) begin
      hdr_byte = {item.fin_flag, 3'b000, item.frame_opcode};
    end else if (idx == 4'd1) begin
      if (is_short) begin
        hdr_byte = {item.use_mask, item.payload_length[6:0]};
      end else if (is_len16) begin
        hdr_byte = {item.use_mask, LEN16_CODE};
      end else begin
        hdr_byte = {item.use_mask, LEN64_CODE};
      end
    end else if (idx < FIXED_HDR + ext_cnt) begin
      // extended length goes out big-endian
      if (is_len16) begin
        hdr_byte = ext_sel[0] ? item.payload_length[7:0] : item.payload_length[15:8];
      end else begin
        hdr_byte = word64_byte({1'b0, item.payload_length}, ~ext_sel[2:0]);
      end
    end else begin
      hdr_byte = key_byte(item.mask_key, key_sel[1:0]);
    end
  end

  assign no_frame  = (state.bytes_left == '0);
  assign mask_byte = state.masking_on ? key_byte(state.held_key, state.key_phase) : 8'h00;
  assign left_dec  = state.bytes_left - 63'd1;

  always_comb begin
    state_nxt = state;
    if (item.operation == OP_FRAME_START) begin
      run_last           = hdr_last;
      result.out_byte    = hdr_byte;
      result.last_in_run = hdr_last;
      result.frame_done  = hdr_last && (item.payload_length == '0);
      result.error_flag  = 1'b0;
      state_nxt.bytes_left = item.payload_length;
      state_nxt.key_phase  = 2'd0;
      state_nxt.masking_on = item.use_mask;
      state_nxt.held_key   = item.use_mask ? item.mask_key : '0;
    end else begin
      run_last           = 1'b1;
      result.last_in_run = 1'b1;
      if (no_frame) begin
        // stray payload byte: dropped, state untouched
        result.out_byte   = 8'h00;
        result.frame_done = 1'b0;
        result.error_flag = 1'b1;
      end else begin
        result.out_byte   = item.payload_byte ^ mask_byte;
        result.frame_done = (left_dec == '0);
        result.error_flag = 1'b0;
        state_nxt.bytes_left = left_dec;
        state_nxt.key_phase  = state.key_phase + 2'd1;
      end
    end
  end

endmodule

// ===== design/wfe_out_stage.sv =====
// ----------------------------------------------------------------------------
// wfe_out_stage
// Result register driving the output channel; loads whenever it is empty
// or its byte is being taken.
// ----------------------------------------------------------------------------
module wfe_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_valid,
  input  wfe_pkg::wfe_out_item_t load_data,
  output logic                   can_load,
  wfe_out_if.source              out_chan
);
  import wfe_pkg::*;

  logic          valid_r;
  logic          valid_nxt;
  wfe_out_item_t data_r;

  assign can_load  = !valid_r || out_chan.ready;
  assign valid_nxt = can_load ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data_r <= load_data;
    end
  end

  assign out_chan.valid = valid_r;
  assign out_chan.data  = data_r;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb - frame encoder testbench
// Drives frame-start and payload requests into the encoder with bursty
// valid, stalls the byte output on its own pattern (one long hold-off to
// back the block up), predicts every serialized byte and checks each
// accepted output byte field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfe_pkg::*;

  localparam int RANDOM_REQS = 145;
  localparam int LONG_HOLD   = 300;
  localparam int PRESSURE_N  = 40;   // requests offered gap-free around the hold-off

  class frame_scoreboard;
    logic [LEN_W-1:0] bytes_left;
    logic [1:0]       key_phase;
    logic [KEY_W-1:0] held_key;
    logic             masking_on;
    wfe_out_item_t    expected_bytes[$];
    int               errors;

    function new();
      bytes_left = '0;
      key_phase  = '0;
      held_key   = '0;
      masking_on = 1'b0;
      errors     = 0;
    endfunction

    // Work out the byte run one accepted request produces.
    function void note_request(wfe_in_item_t r);
      logic [7:0]    hdr[$];
      logic [63:0]   len64;
      logic [7:0]    b;
      wfe_out_item_t e;
      if (r.operation == OP_FRAME_START) begin
        len64 = {1'b0, r.payload_length};
        hdr.push_back({r.fin_flag, 3'b000, r.frame_opcode});
        if (r.payload_length < SHORT_LIMIT) begin
          hdr.push_back({r.use_mask, r.payload_length[6:0]});
        end else if (r.payload_length <= LEN16_MAX) begin
          hdr.push_back({r.use_mask, LEN16_CODE});
          hdr.push_back(len64[15:8]);
          hdr.push_back(len64[7:0]);
        end else begin
          hdr.push_back({r.use_mask, LEN64_CODE});
          for (int i = 7; i >= 0; i--) hdr.push_back(len64[8*i +: 8]);
        end
        if (r.use_mask) begin
          for (int i = 0; i < 4; i++) hdr.push_back(r.mask_key[8*i +: 8]);
        end
        // a new start abandons whatever frame was open
        bytes_left = r.payload_length;
        key_phase  = '0;
        masking_on = r.use_mask;
        held_key   = r.use_mask ? r.mask_key : '0;
        for (int i = 0; i < hdr.size(); i++) begin
          e.out_byte    = hdr[i];
          e.last_in_run = (i == hdr.size() - 1);
          e.frame_done  = (i == hdr.size() - 1) && (r.payload_length == '0);
          e.error_flag  = 1'b0;
          expected_bytes.push_back(e);
        end
      end else if (bytes_left == '0) begin
        // stray payload byte: dropped, error flagged
        e.out_byte    = 8'h00;
        e.last_in_run = 1'b1;
        e.frame_done  = 1'b0;
        e.error_flag  = 1'b1;
        expected_bytes.push_back(e);
      end else begin
        b = r.payload_byte;
        if (masking_on) b = b ^ held_key[8*key_phase +: 8];
        key_phase  = key_phase + 2'd1;
        bytes_left = bytes_left - 1'b1;
        e.out_byte    = b;
        e.last_in_run = 1'b1;
        e.frame_done  = (bytes_left == '0);
        e.error_flag  = 1'b0;
        expected_bytes.push_back(e);
      end
    endfunction

    function void check_byte(wfe_out_item_t got);
      wfe_out_item_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %02h (last %0b done %0b err %0b)",
               got.out_byte, got.last_in_run, got.frame_done, got.error_flag);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (got.out_byte !== e.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", e.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_in_run !== e.last_in_run) begin
        $error("last_in_run: expected %0b, actual %0b", e.last_in_run, got.last_in_run);
        errors++;
      end
      if (got.frame_done !== e.frame_done) begin
        $error("frame_done: expected %0b, actual %0b", e.frame_done, got.frame_done);
        errors++;
      end
      if (got.error_flag !== e.error_flag) begin
        $error("error_flag: expected %0b, actual %0b", e.error_flag, got.error_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  wfe_in_if  in_chan();
  wfe_out_if out_chan();

  websocket_frame_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  frame_scoreboard sb = new();

  int reqs_sent;
  int burst_left;
  bit gaps_off;
  bit hold_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Output side first: nothing accepted at this edge can already be on the output.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) sb.check_byte(out_chan.data);
      if (in_chan.valid && in_chan.ready) sb.note_request(in_chan.data);
    end
  end

  // Receiver: rotating stall patterns plus one long hold-off on request.
  initial begin
    int cyc;
    int mode;
    bit hold_done;
    out_chan.ready = 1'b0;
    cyc = 0;
    mode = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 1) == 1);
          2: out_chan.ready <= (cyc % 3 == 0);
          default: out_chan.ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // Offer one request and hold it until taken; returns at a falling edge.
  task automatic send_req(input wfe_in_item_t r);
    in_chan.valid <= 1'b1;
    in_chan.data  <= r;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    reqs_sent++;
    if (!gaps_off) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  function automatic wfe_in_item_t payload_req(input logic [7:0] b);
    wfe_in_item_t r;
    // header fields carry junk; they do not apply to a payload request
    r.operation      = OP_PAYLOAD_BYTE;
    r.fin_flag       = 1'($urandom_range(0, 1));
    r.frame_opcode   = 4'($urandom_range(0, 15));
    r.payload_length = LEN_W'({$urandom, $urandom});
    r.use_mask       = 1'($urandom_range(0, 1));
    r.mask_key       = $urandom;
    r.payload_byte   = b;
    return r;
  endfunction

  // Frame start followed by n payload bytes (n may fall short of or exceed len).
  task automatic send_frame(input logic fin, input logic [3:0] opc,
                            input logic [LEN_W-1:0] len, input logic m,
                            input logic [KEY_W-1:0] key, input int n);
    wfe_in_item_t r;
    logic [7:0]   b;
    r.operation      = OP_FRAME_START;
    r.fin_flag       = fin;
    r.frame_opcode   = opc;
    r.payload_length = len;
    r.use_mask       = m;
    r.mask_key       = key;
    r.payload_byte   = 8'($urandom);
    send_req(r);
    for (int k = 0; k < n; k++) begin
      b = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom);
      send_req(payload_req(b));
    end
  endtask

  initial begin
    int kind;
    int n;
    logic [LEN_W-1:0] len;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    reqs_sent  = 0;
    burst_left = $urandom_range(1, 10);
    gaps_off   = 1'b0;
    hold_req   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: stray byte, empty frames, every length code boundary, key wrap
    send_req(payload_req(8'hA5));
    send_frame(1'b1, 4'h9, 63'd0, 1'b0, 32'h0, 0);
    send_frame(1'b0, 4'h0, 63'd0, 1'b1, 32'hFFFF_FFFF, 0);
    send_frame(1'b0, 4'h1, 63'd125, 1'b0, 32'h1234_5678, 2);
    send_frame(1'b1, 4'h2, 63'd126, 1'b1, 32'h0000_0000, 3);
    send_frame(1'b1, 4'hA, 63'd65535, 1'b0, 32'hDEAD_BEEF, 1);
    send_frame(1'b0, 4'h8, 63'd65536, 1'b1, 32'h8040_2010, 1);
    send_frame(1'b1, 4'hF, {LEN_W{1'b1}}, 1'b1, 32'hFFFF_FFFF, 2);
    send_frame(1'b1, 4'h2, 63'd5, 1'b1, 32'hA5C3_0F81, 5);
    send_frame(1'b0, 4'h0, 63'd1, 1'b0, 32'h0, 1);
    send_req(payload_req(8'h3C));

    // random: mostly complete small frames, some cut short or overrun
    n = reqs_sent + RANDOM_REQS;
    gaps_off = 1'b1;
    hold_req = 1'b1;
    while (reqs_sent < n) begin
      if (reqs_sent >= n - RANDOM_REQS + PRESSURE_N) gaps_off = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = LEN_W'($urandom_range(0, 12));
        case ($urandom_range(0, 7))
          0: send_frame(1'($urandom), 4'($urandom), len, 1'($urandom), $urandom,
                        $urandom_range(0, 32'(len)));
          1: send_frame(1'($urandom), 4'($urandom), len, 1'($urandom), $urandom,
                        32'(len) + $urandom_range(1, 2));
          default: send_frame(1'($urandom), 4'($urandom), len, 1'($urandom), $urandom,
                              32'(len));
        endcase
      end else if (kind < 65) begin
        len = LEN_W'($urandom_range(120, 131));
        send_frame(1'($urandom), 4'($urandom), len, 1'($urandom), $urandom,
                   $urandom_range(0, 5));
      end else if (kind < 75) begin
        len = LEN_W'($urandom_range(65530, 65540));
        send_frame(1'($urandom), 4'($urandom), len, 1'($urandom), $urandom,
                   $urandom_range(0, 5));
      end else if (kind < 85) begin
        len = LEN_W'({$urandom, $urandom});
        send_frame(1'($urandom), 4'($urandom), len, 1'($urandom), $urandom,
                   $urandom_range(0, 5));
      end else begin
        repeat ($urandom_range(1, 3)) send_req(payload_req(8'($urandom)));
      end
    end
    in_chan.valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
